@@ design/lai_pkg.sv @@
// Shared widths, constants and types for the launch arming interlock.
// No dependencies; every other file of the block imports this package.
package lai_pkg;

	localparam int unsigned IN_W       = 72;
	localparam int unsigned OUT_W      = 32;
	localparam int unsigned ALT_W      = 24;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned SPEED_W    = 24;
	localparam int unsigned SAT_W      = 6;
	localparam int unsigned LIMIT_W    = 16;
	localparam int unsigned DELAY_W    = 20;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 20;

	// Altitude is in cm and time in ms, so mm/s needs a factor of 10 * 1000.
	localparam int unsigned SCALE_W     = 14;
	localparam logic [SCALE_W-1:0] SPEED_SCALE = 14'd10000;
	localparam int unsigned PROD_W      = ALT_W + SCALE_W;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd50;
	localparam logic [DELAY_W-1:0] DELAY_RESET = 20'd10000;
	localparam logic [SAT_W-1:0]   SATS_RESET  = 6'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPEED_LIMIT = 2'd0,
		CFG_ARM_DELAY   = 2'd1,
		CFG_MIN_SATS    = 2'd2
	} cfg_idx_t;

	// Request to the speed divider: start pulse, altitude change and elapsed time.
	typedef struct packed {
		logic               start;
		logic [ALT_W-1:0]   mag;
		logic [TIME_W-1:0]  dt;
	} div_req_t;

	// Response: one-cycle done pulse with the saturated quotient.
	typedef struct packed {
		logic               done;
		logic [SPEED_W-1:0] quot;
	} div_rsp_t;

endpackage

@@ design/lai_div.sv @@
// Bit-serial speed divider: floor(mag * 10000 / dt), saturated to 24 bits.
// Depends on lai_pkg for widths, the scale constant and the request types.
module lai_div import lai_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int unsigned HI_W  = PROD_W - SPEED_W;
	localparam int unsigned CNT_W = $clog2(SPEED_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SPEED_W - 1);

	typedef enum logic [3:0] {
		D_IDLE = 4'b0001,
		D_MUL  = 4'b0010,
		D_CHK  = 4'b0100,
		D_RUN  = 4'b1000
	} div_state_t;

	div_state_t         state_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ALT_W-1:0]   mag_q;
	logic [TIME_W-1:0]  dt_q;
	logic [PROD_W-1:0]  prod_q;
	logic [TIME_W-1:0]  rem_q;
	logic [SPEED_W-1:0] low_q;
	logic [SPEED_W-1:0] quot_q;

	logic [HI_W-1:0]    prod_hi;
	logic               sat;
	logic [TIME_W:0]    trial;
	logic [TIME_W:0]    trial_diff;
	logic               fits;

	// The quotient overflows 24 bits exactly when the upper product bits reach dt.
	assign prod_hi    = prod_q[PROD_W-1:SPEED_W];
	assign sat        = {{(TIME_W-HI_W){1'b0}}, prod_hi} >= dt_q;
	assign trial      = {rem_q, low_q[SPEED_W-1]};
	assign fits       = trial >= {1'b0, dt_q};
	assign trial_diff = trial - {1'b0, dt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (req.start) begin
						state_q <= D_MUL;
					end
				end
				D_MUL: begin
					state_q <= D_CHK;
				end
				D_CHK: begin
					cnt_q <= '0;
					if (sat) begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end else begin
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && req.start) begin
			mag_q <= req.mag;
			dt_q  <= req.dt;
		end
		if (state_q == D_MUL) begin
			prod_q <= PROD_W'(mag_q) * PROD_W'(SPEED_SCALE);
		end
		if (state_q == D_CHK) begin
			rem_q  <= {{(TIME_W-HI_W){1'b0}}, prod_hi};
			low_q  <= prod_q[SPEED_W-1:0];
			quot_q <= sat ? {SPEED_W{1'b1}} : '0;
		end
		if (state_q == D_RUN) begin
			rem_q  <= fits ? trial_diff[TIME_W-1:0] : trial[TIME_W-1:0];
			low_q  <= {low_q[SPEED_W-2:0], 1'b0};
			quot_q <= {quot_q[SPEED_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

@@ design/launch_arming_interlock.sv @@
// Top level of the launch arming interlock: request handling, flags and arming timer.
// Depends on lai_pkg and instantiates the bit-serial divider lai_div.
//
// Usage: each request on the s_ side is one pass of the control loop: button
// levels, a decoded GPS fix (if any) and the millisecond time. For every
// request exactly one result leaves on the m_ side with the two acknowledge
// LEDs, the GPS LED, the arm LED and the current vertical speed in mm/s.
// The cfg channel writes the speed limit, the arming delay and the minimum
// satellite count; cfg_ready is always high and writes are meant for idle time.
//
// Sequencing: one request is worked on at a time; a new one is taken only after
// the last has left its result in the output register. A pass without a new
// speed goes straight to the final stage. A pass that yields a new speed runs
// the serial divider (a multiply step, an overflow check, then one quotient bit
// per cycle over 24 bits) before the final stage; an overflowing speed is
// settled after the check and skips the bit loop.
//
// Reset (arst_n low) clears all flags, the previous fix, the speed and the
// timer, and loads the register defaults. The result sits in an output register:
// when the receiver stalls it holds there, the next request is still accepted,
// and that request finishes only once the waiting result has been taken.
module launch_arming_interlock import lai_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// Bits from 0 up: operator_button, separation_button, fix_present,
	// satellite_count[5:0], location_ok, altitude_ok, altitude_cm[23:0],
	// now_ms[31:0], zero padding.
	input  logic [IN_W-1:0]       s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// Bits from 0 up: operator_led, separation_led, gps_led, arm_led,
	// vertical_speed[23:0], zero padding.
	output logic [OUT_W-1:0]      m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [LIMIT_W-1:0] limit_q;
	logic [DELAY_W-1:0] delay_q;
	logic [SAT_W-1:0]   min_sats_q;

	// Loop state.
	logic               op_prev_q;
	logic               sep_prev_q;
	logic               op_ack_q;
	logic               sep_ack_q;
	logic               fix_valid_q;
	logic               have_prev_q;
	logic [ALT_W-1:0]   prev_alt_q;
	logic [TIME_W-1:0]  prev_time_q;
	logic [SPEED_W-1:0] speed_q;
	logic               timing_active_q;
	logic [TIME_W-1:0]  timing_start_q;

	// Time of the request under work, and the output register.
	logic [TIME_W-1:0]  now_q;
	logic               m_tvalid_q;
	logic [OUT_W-1:0]   m_tdata_q;

	// Unpacked request fields.
	logic               in_op;
	logic               in_sep;
	logic               in_present;
	logic [SAT_W-1:0]   in_sats;
	logic               in_loc_ok;
	logic               in_alt_ok;
	logic [ALT_W-1:0]   in_alt;
	logic [TIME_W-1:0]  in_now;

	assign in_op      = s_tdata[0];
	assign in_sep     = s_tdata[1];
	assign in_present = s_tdata[2];
	assign in_sats    = s_tdata[8:3];
	assign in_loc_ok  = s_tdata[9];
	assign in_alt_ok  = s_tdata[10];
	assign in_alt     = s_tdata[34:11];
	assign in_now     = s_tdata[66:35];

	logic               accept;
	logic               fix_ok;
	logic [TIME_W-1:0]  dt;
	logic [ALT_W:0]     alt_diff;
	logic [ALT_W-1:0]   alt_mag;
	logic               need_div;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// A fix counts when enough satellites are in use and both position flags are set.
	assign fix_ok   = (in_sats >= min_sats_q) && in_loc_ok && in_alt_ok;
	assign dt       = in_now - prev_time_q;
	// The altitude change of two 24-bit values needs 25 bits; its magnitude fits 24.
	assign alt_diff = {in_alt[ALT_W-1], in_alt} - {prev_alt_q[ALT_W-1], prev_alt_q};
	assign alt_mag  = alt_diff[ALT_W] ? ALT_W'(~alt_diff + 1'b1) : alt_diff[ALT_W-1:0];
	// A speed is computed only against an earlier fix and a nonzero time step.
	assign need_div = in_present && fix_ok && have_prev_q && (dt != '0);

	assign div_req.start = accept && need_div;
	assign div_req.mag   = alt_mag;
	assign div_req.dt    = dt;

	lai_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Final stage: the LEDs and the arming timer, evaluated with the updated speed.
	logic               out_load;
	logic               gps_ok;
	logic               arm_ok;
	logic [TIME_W-1:0]  elapsed;
	logic               arm;

	assign out_load = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);
	assign gps_ok   = fix_valid_q && (speed_q < {{(SPEED_W-LIMIT_W){1'b0}}, limit_q});
	assign arm_ok   = op_ack_q && sep_ack_q && gps_ok;
	// A timer that starts in this pass starts at now, so the elapsed time is zero.
	assign elapsed  = timing_active_q ? (now_q - timing_start_q) : '0;
	assign arm      = arm_ok && (elapsed >= {{(TIME_W-DELAY_W){1'b0}}, delay_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			op_prev_q       <= 1'b0;
			sep_prev_q      <= 1'b0;
			op_ack_q        <= 1'b0;
			sep_ack_q       <= 1'b0;
			fix_valid_q     <= 1'b0;
			have_prev_q     <= 1'b0;
			prev_alt_q      <= '0;
			prev_time_q     <= '0;
			speed_q         <= '0;
			timing_active_q <= 1'b0;
			timing_start_q  <= '0;
			m_tvalid_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// A rising edge on a button toggles its acknowledge flag.
						op_ack_q   <= op_ack_q ^ (in_op && !op_prev_q);
						sep_ack_q  <= sep_ack_q ^ (in_sep && !sep_prev_q);
						op_prev_q  <= in_op;
						sep_prev_q <= in_sep;
						if (in_present) begin
							fix_valid_q <= fix_ok;
							if (fix_ok) begin
								prev_alt_q  <= in_alt;
								prev_time_q <= in_now;
								have_prev_q <= 1'b1;
							end
						end
						state_q <= need_div ? ST_DIV : ST_FIN;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						speed_q <= div_rsp.quot;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						if (arm_ok) begin
							if (!timing_active_q) begin
								timing_start_q <= now_q;
							end
							timing_active_q <= 1'b1;
						end else begin
							timing_active_q <= 1'b0;
							timing_start_q  <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= in_now;
		end
		if (out_load) begin
			m_tdata_q <= {{(OUT_W-SPEED_W-4){1'b0}}, speed_q, arm, gps_ok, sep_ack_q, op_ack_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Register writes; an index past the list is dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q    <= LIMIT_RESET;
			delay_q    <= DELAY_RESET;
			min_sats_q <= SATS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SPEED_LIMIT: limit_q    <= cfg_data[LIMIT_W-1:0];
				CFG_ARM_DELAY:   delay_q    <= cfg_data[DELAY_W-1:0];
				CFG_MIN_SATS:    min_sats_q <= cfg_data[SAT_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

@@ design/lai_checker.sv @@
// Port-level assertions for the launch arming interlock, bound to the top level.
// Depends on lai_pkg for the port widths.
module lai_checker import lai_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_W-1:0]      m_tdata
);

	logic [1:0] pending_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// Requests accepted whose results have not been taken yet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {1'b0, in_acc} - {1'b0, out_acc};
		end
	end

	// One request is worked on at a time: acceptance drops ready.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("request accepted while another one is at work");

	// A result never appears without an outstanding request, and at most two wait.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (pending_q != 2'd0) && (pending_q != 2'd3))
		else $error("result without matching request");

	// Arming implies both acknowledges and the GPS condition.
	a_arm_needs_all: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> m_tdata[0] && m_tdata[1] && m_tdata[2])
		else $error("arm_led without all conditions");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind launch_arming_interlock lai_checker u_lai_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

@@ verif/lai_lamp_checker.sv @@
`timescale 1ns / 100ps
// Result checker for launch_arming_interlock: watches the request, result and register
// channels, predicts every result and compares it field by field. Depends on lai_pkg.
module lai_lamp_checker import lai_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_W-1:0]       s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_W-1:0]      m_tdata,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    pending_results,
	output int                    failures
);

	// Declared from the top bit down, so the last field lands in bit 0.
	typedef struct packed {
		logic [TIME_W-1:0] now_ms;
		logic [ALT_W-1:0]  altitude_cm;
		logic              altitude_ok;
		logic              location_ok;
		logic [SAT_W-1:0]  satellite_count;
		logic              fix_present;
		logic              separation_button;
		logic              operator_button;
	} loop_pass_t;

	typedef struct packed {
		logic [SPEED_W-1:0] vertical_speed;
		logic               arm_led;
		logic               gps_led;
		logic               separation_led;
		logic               operator_led;
	} lamps_t;

	localparam int unsigned PASS_W  = $bits(loop_pass_t);
	localparam int unsigned LAMPS_W = $bits(lamps_t);
	localparam logic [SPEED_W-1:0] SPEED_CEIL = '1;

	logic [LIMIT_W-1:0] speed_limit;
	logic [DELAY_W-1:0] hold_ms;
	logic [SAT_W-1:0]   sats_needed;

	logic               op_level, sep_level, op_ack, sep_ack;
	logic               fix_ok, have_fix, timing;
	logic [ALT_W-1:0]   last_alt;
	logic [TIME_W-1:0]  last_fix_ms, timing_start;
	logic [SPEED_W-1:0] speed;

	lamps_t lamps_due[$];

	initial failures = 0;

	function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
		failures++;
		if (failures <= 10)
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
	endfunction

	// One pass of the control loop: button edges, fix bookkeeping, speed and arming timer.
	function automatic lamps_t advance_interlock(input loop_pass_t p);
		lamps_t            lamps;
		logic [TIME_W-1:0] elapsed;
		longint            delta;
		longint unsigned   rate;
		logic              gps_ok;
		if (p.operator_button && !op_level)
			op_ack = !op_ack;
		op_level = p.operator_button;
		if (p.separation_button && !sep_level)
			sep_ack = !sep_ack;
		sep_level = p.separation_button;

		if (p.fix_present) begin
			if (p.satellite_count >= sats_needed && p.location_ok && p.altitude_ok) begin
				elapsed = p.now_ms - last_fix_ms;
				if (have_fix && elapsed != '0) begin
					delta = longint'($signed(p.altitude_cm)) - longint'($signed(last_alt));
					rate = (delta < 0) ? -delta : delta;
					// cm to mm is a factor 10, ms to s a factor 1000.
					rate = rate * 10000 / elapsed;
					speed = (rate > SPEED_CEIL) ? SPEED_CEIL : rate[SPEED_W-1:0];
				end
				last_alt    = p.altitude_cm;
				last_fix_ms = p.now_ms;
				have_fix    = 1'b1;
				fix_ok      = 1'b1;
			end else begin
				fix_ok = 1'b0;
			end
		end

		gps_ok = fix_ok && (speed < speed_limit);
		lamps.arm_led = 1'b0;
		if (op_ack && sep_ack && gps_ok) begin
			if (!timing) begin
				timing_start = p.now_ms;
				timing       = 1'b1;
			end
			lamps.arm_led = (p.now_ms - timing_start) >= hold_ms;
		end else begin
			timing       = 1'b0;
			timing_start = '0;
		end
		lamps.operator_led   = op_ack;
		lamps.separation_led = sep_ack;
		lamps.gps_led        = gps_ok;
		lamps.vertical_speed = speed;
		return lamps;
	endfunction

	function automatic void compare_lamps(input lamps_t want, input logic [OUT_W-1:0] word);
		lamps_t got;
		got = lamps_t'(word[LAMPS_W-1:0]);
		if (got.operator_led !== want.operator_led)
			flag_mismatch("operator_led", want.operator_led, got.operator_led);
		if (got.separation_led !== want.separation_led)
			flag_mismatch("separation_led", want.separation_led, got.separation_led);
		if (got.gps_led !== want.gps_led)
			flag_mismatch("gps_led", want.gps_led, got.gps_led);
		if (got.arm_led !== want.arm_led)
			flag_mismatch("arm_led", want.arm_led, got.arm_led);
		if (got.vertical_speed !== want.vertical_speed)
			flag_mismatch("vertical_speed", want.vertical_speed, got.vertical_speed);
		if (word[OUT_W-1:LAMPS_W] !== '0)
			flag_mismatch("padding", 0, word[OUT_W-1:LAMPS_W]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_limit  = LIMIT_RESET;
			hold_ms      = DELAY_RESET;
			sats_needed  = SATS_RESET;
			op_level     = 1'b0;
			sep_level    = 1'b0;
			op_ack       = 1'b0;
			sep_ack      = 1'b0;
			fix_ok       = 1'b0;
			have_fix     = 1'b0;
			timing       = 1'b0;
			last_alt     = '0;
			last_fix_ms  = '0;
			timing_start = '0;
			speed        = '0;
			lamps_due.delete();
			pending_results = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SPEED_LIMIT: speed_limit = cfg_data[LIMIT_W-1:0];
					CFG_ARM_DELAY:   hold_ms     = cfg_data[DELAY_W-1:0];
					CFG_MIN_SATS:    sats_needed = cfg_data[SAT_W-1:0];
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready)
				lamps_due.push_back(advance_interlock(loop_pass_t'(s_tdata[PASS_W-1:0])));
			if (m_tvalid && m_tready) begin
				if (lamps_due.size() == 0)
					flag_mismatch("unrequested result", 0, m_tdata);
				else
					compare_lamps(lamps_due.pop_front(), m_tdata);
			end
			pending_results = lamps_due.size();
		end
	end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Regression top for launch_arming_interlock: clock, reset, request and register
// stimulus, result back pressure and the verdict. Depends on lai_pkg, the block
// and lai_lamp_checker, which predicts and compares every result.
module tb;
	import lai_pkg::*;

	// Register index past the end of the map; the block must ignore writes to it.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	// Cycles without any handshake before the run is declared hung. The slowest
	// legal gap is the long receiver hold plus a divider run, well under this.
	localparam int WATCHDOG_CYCLES  = 5000;
	localparam int LONG_HOLD_CYCLES = 300;
	// A pass with a new speed runs the serial divider; leave room after the last one.
	localparam int SETTLE_CYCLES    = 40;
	localparam int PAD_W = IN_W - (TIME_W + ALT_W + SAT_W + 5);

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_W-1:0]      m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int pending_results;
	int failures;

	// Idle percentages for either side, set per phase by the stimulus process.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_off_due  = 1'b0;

	// Stimulus-side view of what was sent: the button levels, the acknowledge
	// flags those levels imply, the satellite floor in force, time and altitude.
	logic              op_sent   = 1'b0;
	logic              sep_sent  = 1'b0;
	logic              op_lit    = 1'b0;
	logic              sep_lit   = 1'b0;
	int unsigned       sats_floor = 32'(SATS_RESET);
	logic [TIME_W-1:0] clock_ms  = '0;
	int                altitude  = 0;

	always #4 clk = ~clk;

	launch_arming_interlock i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	lai_lamp_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.pending_results (pending_results),
		.failures        (failures)
	);

	// Offers one request, with random idle cycles in front of it. Entered and left
	// at a falling edge; s_tvalid stays high if the next request follows at once.
	task automatic drive_pass(input logic op, sep, fix, input logic [SAT_W-1:0] sats,
		input logic loc, alt_ok, input logic [ALT_W-1:0] alt, input logic [TIME_W-1:0] now);
		if (op && !op_sent)
			op_lit = !op_lit;
		if (sep && !sep_sent)
			sep_lit = !sep_lit;
		op_sent  = op;
		sep_sent = sep;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{PAD_W{1'b0}}, now, alt, alt_ok, loc, sats, fix, sep, op};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Mostly a believable flight sequence: buttons steered so that both acknowledges
	// are usually set, time moving forward, altitude nearly still and good fixes.
	// The rest is noise over the full range of every field.
	task automatic random_pass();
		int               roll;
		logic             op, sep;
		logic [SAT_W-1:0] sats;
		roll = $urandom_range(0, 99);
		if (roll < 15) begin
			drive_pass(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), SAT_W'($urandom_range(0, 63)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				ALT_W'($urandom_range(0, 16777215)), $urandom);
		end else begin
			// A flag that disagrees with the wanted state gets its button flipped;
			// from a high level that takes two requests, a release and a press.
			op  = op_sent;
			sep = sep_sent;
			if (op_lit != ($urandom_range(0, 29) != 0))
				op = !op_sent;
			if (sep_lit != ($urandom_range(0, 29) != 0))
				sep = !sep_sent;

			// Time: mostly steady steps, sometimes long jumps that can reach the
			// longest arming delay, a step back, a fresh stamp or a repeated one.
			roll = $urandom_range(0, 99);
			if (roll < 75)
				clock_ms += $urandom_range(100, 2500);
			else if (roll < 85)
				clock_ms += $urandom_range(0, 700000);
			else if (roll < 90)
				clock_ms -= $urandom_range(1, 100000);
			else if (roll < 95)
				clock_ms = $urandom;

			roll = $urandom_range(0, 99);
			if (roll >= 90)
				altitude = int'($urandom_range(0, 5100000)) - 100000;
			else if (roll >= 70)
				altitude += int'($urandom_range(0, 4000)) - 2000;
			else if (roll >= 40)
				altitude += int'($urandom_range(0, 6)) - 3;
			if (altitude < -100000)
				altitude = -100000;
			else if (altitude > 5000000)
				altitude = 5000000;

			if ($urandom_range(0, 99) < 85)
				sats = SAT_W'($urandom_range(sats_floor, 63));
			else
				sats = SAT_W'($urandom_range(0, 63));
			drive_pass(op, sep, $urandom_range(0, 99) < 85, sats,
				$urandom_range(0, 99) < 95, $urandom_range(0, 99) < 95,
				altitude[ALT_W-1:0], clock_ms);
		end
	endtask

	// Writes the three registers, and optionally the unmapped index, back to back.
	// Only called while nothing is in flight.
	task automatic set_regs(input logic [CFG_DATA_W-1:0] limit_word, delay_word, sats_word,
		input bit poke_unused);
		logic [CFG_IDX_W-1:0]  idx [4];
		logic [CFG_DATA_W-1:0] val [4];
		int                    count;
		idx   = '{CFG_SPEED_LIMIT, CFG_ARM_DELAY, CFG_MIN_SATS, CFG_UNUSED};
		val   = '{limit_word, delay_word, sats_word,
			CFG_DATA_W'($urandom_range(0, 1048575))};
		count = poke_unused ? 4 : 3;
		for (int i = 0; i < count; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			do @(posedge clk); while (!cfg_ready);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
		sats_floor = 32'(sats_word[SAT_W-1:0]);
	endtask

	// Sender pause: lets every outstanding result arrive before going on.
	task automatic wait_drained();
		do @(negedge clk); while (pending_results != 0);
	endtask

	task automatic run_phase(input int tx_idle, rx_idle,
		input logic [CFG_DATA_W-1:0] limit_word, delay_word, sats_word,
		input bit poke_unused, input int passes);
		send_idle_pct = tx_idle;
		recv_idle_pct = rx_idle;
		set_regs(limit_word, delay_word, sats_word, poke_unused);
		repeat (passes)
			random_pass();
		s_tvalid <= 1'b0;
		wait_drained();
	endtask

	// Result side: random back pressure, plus one long hold-off while the sender
	// keeps offering, so the output register fills and the input stalls.
	initial begin : result_drain
		bit held;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_due && !held) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Ends a hung run: counts cycles in which no handshake completes on any channel.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("launch_arming_interlock regression: fail");
		$finish;
	end

	initial begin : stimulus
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed requests with the reset register values: limit 50 mm/s,
		// delay 10000 ms, at least 3 satellites.
		send_idle_pct = 31;
		recv_idle_pct = 80;
		drive_pass(0, 0, 0, 0, 0, 0, 0, 0);
		drive_pass(1, 0, 0, 0, 0, 0, 0, 10);            // operator press
		drive_pass(1, 1, 0, 0, 0, 0, 0, 20);            // separation press, operator held
		drive_pass(1, 1, 1, 2, 1, 1, 0, 30);            // too few satellites
		drive_pass(1, 1, 1, 3, 1, 1, 0, 1000);          // first valid fix, count at minimum
		drive_pass(1, 1, 1, 40, 0, 1, 500, 1500);       // location invalid
		drive_pass(1, 1, 1, 40, 1, 0, 500, 1600);       // altitude invalid
		drive_pass(1, 1, 1, 40, 1, 1, 100, 1000);       // zero elapsed time since last fix
		drive_pass(1, 1, 1, 40, 1, 1, 100, 2000);       // still, timer running
		drive_pass(1, 1, 0, 0, 0, 0, 0, 11000);         // delay met exactly, no fix
		drive_pass(1, 1, 1, 63, 1, 1, 24'h7FFFFF, 12000); // jump to top altitude, far over the limit
		drive_pass(1, 1, 1, 63, 1, 1, 24'h800000, 12001); // bottom altitude in one ms
		drive_pass(1, 1, 1, 63, 1, 1, 24'h800000, 5);   // time going backwards
		drive_pass(1, 1, 1, 9, 1, 1, -24'sd100000, 32'hFFFFFFFF);
		drive_pass(1, 1, 1, 9, 1, 1, -24'sd100000, 999); // time wraps past zero
		drive_pass(1, 1, 0, 0, 0, 0, 0, 10999);         // delay met across the wrap
		drive_pass(0, 1, 0, 0, 0, 0, 0, 11500);         // operator released
		drive_pass(1, 1, 0, 0, 0, 0, 0, 12000);         // operator toggles off, arming drops
		drive_pass(1, 0, 1, 63, 1, 1, 24'd5000000, 20000);
		drive_pass(1, 1, 0, 0, 0, 0, 0, 20100);         // separation toggles off
		drive_pass(1, 1, 1, 63, 1, 1, 24'hFFFFFF, 32'hFFFFFFFF);
		drive_pass(0, 0, 1, 0, 1, 1, 0, 32'hFFFFFFFF);  // zero satellites
		s_tvalid <= 1'b0;
		wait_drained();

		clock_ms = $urandom;
		// Widest limit, no delay, any satellite count: arming comes easily.
		run_phase(31, 80, 20'd65535, 20'd0, 20'd0, 1'b0, 130);
		// Zero limit keeps the GPS lamp dark; longest delay, most satellites.
		run_phase(31, 80, 20'd0, 20'd600000, 20'd63, 1'b0, 60);
		// Receiver goes quiet for a long stretch at the start of this phase.
		hold_off_due = 1'b1;
		run_phase(80, 31, 20'd1000, 20'd1000, 20'd4, 1'b0, 130);
		run_phase(80, 31, 20'd65535, 20'd600000, 20'd1, 1'b0, 120);
		// Out-of-range data: only the low bits count (limit 50, 5 satellites),
		// and a write to the unmapped index changes nothing.
		run_phase(0, 0, 20'hF0032, 20'd5000, 20'h3FF05, 1'b1, 110);
		run_phase(0, 0, 20'd200, 20'd20000, 20'd3, 1'b0, 100);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0 && pending_results == 0)
			$display("launch_arming_interlock regression: pass");
		else
			$display("launch_arming_interlock regression: fail");
		$finish;
	end

endmodule
